// ===== hw/rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, codes and controller/datapath types of the first-fit
// block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

	// Page geometry (grain size is a power of two)
	localparam int PAGE_BYTES  = 4096;
	localparam int GRAIN_BYTES = 8;
	localparam int NGRAIN      = PAGE_BYTES / GRAIN_BYTES;
	localparam int AW          = $clog2(NGRAIN);
	localparam int CW          = AW + 1;
	localparam int GL          = $clog2(GRAIN_BYTES);

	// Field widths
	localparam int SIZE_W = 13;
	localparam int OFF_W  = 12;
	localparam int NEED_W = SIZE_W;
	localparam int IN_W   = 32;
	localparam int OUT_W  = 16;

	// Request kinds
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SIZE  = 2'd1,
		ST_NO_FIT    = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_A_SCAN,
		S_A_MARK,
		S_F_RD,
		S_F_CHK,
		S_F_WALK,
		S_MERGE,
		S_RESP
	} state_t;

	// Controller to datapath
	typedef struct packed {
		state_t  phase;
		logic    load;
		logic    emit;
		status_t code;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_done;
		logic is_alloc;
		logic bad_size;
		logic bad_off;
		logic a_hit;
		logic a_end;
		logic mark_done;
		logic chk_ok;
		logic walk_done;
		logic merge_done;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/first_fit_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit allocator over one page of granules with merging of freed blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: s_tuser is the kind (0 allocate, 1 free),
//   s_tdata carries the size in bytes and the offset to release. Each request
//   yields exactly one result beat on the m_ channel: a status code and, on a
//   good allocate, the byte offset of the block.
//   One request is handled at a time. An allocate walks the mark memories one
//   granule a cycle until the first fitting block, then clears the free marks
//   of the taken granules one a cycle. A free checks the start mark, walks the
//   block setting free marks, then runs a full merge pass over all 512
//   granules. Bad sizes and misaligned offsets are answered from the decode
//   step, an offset that is no block start after its start mark is read. The
//   walks go through the single-read-port mark memories.
//   After reset a clearing pass over all 512 granules initialises the
//   memories; no request is taken during it. The result sits in an output
//   register, so a stalled receiver does not stop the next request from being
//   accepted; only the following result waits until the register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [ffa_pkg::IN_W-1:0]  s_tdata,   // size_bytes[12:0], release_offset[24:13]
	input  wire logic                      s_tuser,   // req_type
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic      [ffa_pkg::OUT_W-1:0] m_tdata    // status[1:0], block_offset[13:2]
);

	ffa_pkg::cmd_t  cmd;
	ffa_pkg::stat_t stat;

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffa_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer of the allocator: clearing pass, request decode, first-fit scan,
// marking, free walk, merge pass and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire ffa_pkg::stat_t stat,
	output ffa_pkg::cmd_t       cmd
);

	ffa_pkg::state_t  state_q, state_d;
	ffa_pkg::status_t code_q, code_d;

	// Next state and result code
	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		unique case (state_q)
			ffa_pkg::S_CLEAR: begin
				if (stat.clear_done) state_d = ffa_pkg::S_IDLE;
			end
			ffa_pkg::S_IDLE: begin
				if (s_tvalid) state_d = ffa_pkg::S_DECIDE;
			end
			ffa_pkg::S_DECIDE: begin
				if (stat.is_alloc) begin
					if (stat.bad_size) begin
						state_d = ffa_pkg::S_RESP;
						code_d  = ffa_pkg::ST_BAD_SIZE;
					end else begin
						state_d = ffa_pkg::S_A_SCAN;
					end
				end else if (stat.bad_off) begin
					state_d = ffa_pkg::S_RESP;
					code_d  = ffa_pkg::ST_NOT_FOUND;
				end else begin
					state_d = ffa_pkg::S_F_RD;
				end
			end
			ffa_pkg::S_A_SCAN: begin
				if (stat.a_hit) begin
					state_d = ffa_pkg::S_A_MARK;
				end else if (stat.a_end) begin
					state_d = ffa_pkg::S_RESP;
					code_d  = ffa_pkg::ST_NO_FIT;
				end
			end
			ffa_pkg::S_A_MARK: begin
				if (stat.mark_done) begin
					state_d = ffa_pkg::S_RESP;
					code_d  = ffa_pkg::ST_OK;
				end
			end
			ffa_pkg::S_F_RD: begin
				state_d = ffa_pkg::S_F_CHK;
			end
			ffa_pkg::S_F_CHK: begin
				if (stat.chk_ok) begin
					state_d = ffa_pkg::S_F_WALK;
				end else begin
					state_d = ffa_pkg::S_RESP;
					code_d  = ffa_pkg::ST_NOT_FOUND;
				end
			end
			ffa_pkg::S_F_WALK: begin
				if (stat.walk_done) state_d = ffa_pkg::S_MERGE;
			end
			ffa_pkg::S_MERGE: begin
				if (stat.merge_done) begin
					state_d = ffa_pkg::S_RESP;
					code_d  = ffa_pkg::ST_OK;
				end
			end
			ffa_pkg::S_RESP: begin
				if (stat.out_free) state_d = ffa_pkg::S_IDLE;
			end
			default: state_d = ffa_pkg::S_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready  = (state_q == ffa_pkg::S_IDLE);
		cmd.phase = state_q;
		cmd.load  = (state_q == ffa_pkg::S_IDLE) && s_tvalid;
		cmd.emit  = (state_q == ffa_pkg::S_RESP) && stat.out_free;
		cmd.code  = code_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffa_pkg::S_CLEAR;
			code_q  <= ffa_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ffa_dp.sv =====
// ----------------------------------------------------------------------------
// ffa_dp
// Datapath of the allocator: start and free mark memories, walk counter,
// read pipeline, block tracking and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ffa_pkg::cmd_t               cmd,
	output ffa_pkg::stat_t                   stat,
	input  wire logic [ffa_pkg::IN_W-1:0]    s_tdata,
	input  wire logic                        s_tuser,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic      [ffa_pkg::OUT_W-1:0]   m_tdata
);

	localparam int AW = ffa_pkg::AW;
	localparam int CW = ffa_pkg::CW;
	localparam int NW = ffa_pkg::NEED_W;

	// Request fields
	logic [ffa_pkg::SIZE_W-1:0] size_in;
	logic [ffa_pkg::OFF_W-1:0]  roff_in, goff_in;
	assign size_in = s_tdata[ffa_pkg::SIZE_W-1:0];
	assign roff_in = s_tdata[ffa_pkg::SIZE_W +: ffa_pkg::OFF_W];
	assign goff_in = roff_in >> ffa_pkg::GL;

	logic          typ_q, bad_size_q, bad_off_q;
	logic [NW-1:0] need_q, cnt_q;
	logic [AW-1:0] g_q, bs_q, a_s1;
	logic [CW-1:0] rd_q, run_q, split_q;
	logic          v_s1, fr_q, prevf_q, found_q, end_q, stop_q;
	logic          out_v_q;
	logic [ffa_pkg::OFF_W-1:0] out_off_q;
	ffa_pkg::status_t          out_st_q;

	// Memory ports
	logic          sdat, fdat;
	logic          s_we, s_wd, f_we, f_wd;
	logic [AW-1:0] s_wa, f_wa, raddr;
	assign raddr = rd_q[AW-1:0];

	ffa_ram #(.WIDTH(1), .DEPTH(ffa_pkg::NGRAIN)) u_start_ram (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(raddr), .rdata(sdat)
	);

	ffa_ram #(.WIDTH(1), .DEPTH(ffa_pkg::NGRAIN)) u_free_ram (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(raddr), .rdata(fdat)
	);

	// Block tracking during the first-fit scan
	logic          st_n, fr_n, hit, scan_go, at_end;
	logic [CW-1:0] run_n;
	logic [AW-1:0] bs_n;
	assign at_end  = (rd_q == CW'(ffa_pkg::NGRAIN));
	assign scan_go = (cmd.phase == ffa_pkg::S_A_SCAN) && v_s1 && !found_q && !end_q;
	assign st_n    = sdat;
	assign run_n   = st_n ? CW'(1) : run_q + CW'(1);
	assign fr_n    = st_n ? fdat : fr_q;
	assign bs_n    = st_n ? a_s1 : bs_q;
	assign hit     = scan_go && fr_n && (NW'(run_n) == need_q);

	logic walk_done, merge_done;
	assign walk_done  = stop_q || (at_end && !v_s1);
	assign merge_done = at_end && !v_s1;

	// Read issue and memory writes per phase
	logic issue;
	always_comb begin
		issue = 1'b0;
		s_we  = 1'b0;
		s_wa  = raddr;
		s_wd  = 1'b0;
		f_we  = 1'b0;
		f_wa  = raddr;
		f_wd  = 1'b0;
		unique case (cmd.phase)
			ffa_pkg::S_CLEAR: begin
				s_we = 1'b1;
				s_wd = (rd_q == '0);
				f_we = 1'b1;
				f_wd = 1'b1;
			end
			ffa_pkg::S_A_SCAN: begin
				issue = !at_end && !found_q && !end_q;
			end
			ffa_pkg::S_A_MARK: begin
				f_we = 1'b1;
				f_wd = 1'b0;
				s_we = (cnt_q == '0) && (split_q < CW'(ffa_pkg::NGRAIN));
				s_wa = split_q[AW-1:0];
				s_wd = 1'b1;
			end
			ffa_pkg::S_F_RD: begin
				issue = 1'b1;
			end
			ffa_pkg::S_F_CHK: begin
				f_we = sdat;
				f_wa = g_q;
				f_wd = 1'b1;
			end
			ffa_pkg::S_F_WALK: begin
				issue = !at_end && !walk_done;
				f_we  = v_s1 && !stop_q && !sdat;
				f_wa  = a_s1;
				f_wd  = 1'b1;
			end
			ffa_pkg::S_MERGE: begin
				issue = !at_end;
				s_we  = v_s1 && (a_s1 != '0) && sdat && fdat && prevf_q;
				s_wa  = a_s1;
				s_wd  = 1'b0;
			end
			default: ;
		endcase
	end

	// Status towards the controller
	always_comb begin
		stat.clear_done = (cmd.phase == ffa_pkg::S_CLEAR) && (rd_q == CW'(ffa_pkg::NGRAIN - 1));
		stat.is_alloc   = (typ_q == ffa_pkg::REQ_ALLOC);
		stat.bad_size   = bad_size_q;
		stat.bad_off    = bad_off_q;
		stat.a_hit      = found_q;
		stat.a_end      = end_q;
		stat.mark_done  = (cmd.phase == ffa_pkg::S_A_MARK) && (cnt_q == need_q - NW'(1));
		stat.chk_ok     = sdat;
		stat.walk_done  = walk_done;
		stat.merge_done = merge_done;
		stat.out_free   = !out_v_q || m_tready;
	end

	// Control registers: counter, read pipeline, scan flags, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			v_s1    <= 1'b0;
			found_q <= 1'b0;
			end_q   <= 1'b0;
			stop_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (cmd.load) begin
				rd_q    <= (s_tuser == ffa_pkg::REQ_FREE) ? CW'(goff_in) : '0;
				found_q <= 1'b0;
				end_q   <= 1'b0;
				stop_q  <= 1'b0;
			end else if (hit) begin
				rd_q    <= CW'(bs_n);
				found_q <= 1'b1;
			end else if (cmd.phase == ffa_pkg::S_F_WALK && walk_done) begin
				rd_q <= '0;
			end else if (issue || cmd.phase == ffa_pkg::S_CLEAR
					|| cmd.phase == ffa_pkg::S_A_MARK) begin
				rd_q <= rd_q + CW'(1);
			end
			if (scan_go && !hit && a_s1 == AW'(ffa_pkg::NGRAIN - 1)) begin
				end_q <= 1'b1;
			end
			if (cmd.phase == ffa_pkg::S_F_WALK && v_s1 && sdat) begin
				stop_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		a_s1    <= raddr;
		prevf_q <= (cmd.phase == ffa_pkg::S_MERGE && v_s1) ? fdat : 1'b0;
		if (cmd.load) begin
			typ_q      <= s_tuser;
			need_q     <= NW'(size_in >> ffa_pkg::GL);
			bad_size_q <= (size_in == '0)
				|| ((size_in & ffa_pkg::SIZE_W'(ffa_pkg::GRAIN_BYTES - 1)) != '0);
			bad_off_q  <= ((roff_in & ffa_pkg::OFF_W'(ffa_pkg::GRAIN_BYTES - 1)) != '0)
				|| (32'(goff_in) >= ffa_pkg::NGRAIN);
			g_q        <= goff_in[AW-1:0];
			cnt_q      <= '0;
		end
		if (scan_go) begin
			run_q <= run_n;
			fr_q  <= fr_n;
			bs_q  <= bs_n;
		end
		if (hit) begin
			split_q <= CW'(bs_n) + CW'(need_q);
			cnt_q   <= '0;
		end else if (cmd.phase == ffa_pkg::S_A_MARK) begin
			cnt_q <= cnt_q + NW'(1);
		end
		if (cmd.emit) begin
			out_st_q  <= cmd.code;
			out_off_q <= (cmd.code == ffa_pkg::ST_OK && typ_q == ffa_pkg::REQ_ALLOC)
				? ffa_pkg::OFF_W'(32'(bs_q) << ffa_pkg::GL) : '0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {(ffa_pkg::OUT_W - ffa_pkg::OFF_W - 2)'(0), out_off_q, out_st_q};

endmodule

`default_nettype wire

// ===== hw/rtl/ffa_checker.sv =====
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_tvalid,
	input wire logic                      s_tready,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [ffa_pkg::OUT_W-1:0] m_tdata
);

	// Hold a stalled result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Drop ready after an accepted request until its result is produced
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in flight");

	// Error results carry a zero offset
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != 2'd0) |-> (m_tdata[13:2] == '0))
		else $error("error result with non-zero offset");

	// Keep the pad bits clear
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:14] == 2'b00))
		else $error("result pad bits set");

endmodule

bind first_fit_block_allocator_top ffa_checker u_ffa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
